>>> hdl/sdfe_pkg.sv
// Shared types and constants for the delimited frame extractor.
// Used by sdfe_front, sdfe_engine and the top module; depends on nothing.
package sdfe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_START_PATTERN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_PATTERN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SENTENCES = 3'd4;

  localparam logic [4:0] FRAME_LIMIT_MAX = 5'd16;

  localparam int IN_Q_DEPTH  = 4;
  localparam int OUT_Q_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_FIN   = 2'd2
  } kind_t;

  typedef struct packed {
    logic       is_term;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] frame_byte;
    logic [3:0] frame_index;
    logic [6:0] byte_position;
    logic       overflow;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [63:0] start_pattern;
    logic [3:0]  start_length;
    logic [63:0] end_pattern;
    logic [3:0]  end_length;
    logic [4:0]  max_sentences;
  } cfg_t;

endpackage

>>> hdl/sdfe_fifo.sv
// Small register-based first-in first-out queue with show-ahead read.
// Standalone; used for the input and the result queues.
module sdfe_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/sdfe_front.sv
// Front part: takes text bytes, marks the terminator and queues them.
// Depends on sdfe_pkg and sdfe_fifo.
module sdfe_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [7:0]      text_byte,
  output logic            full,
  output logic            item_valid,
  output sdfe_pkg::item_t item,
  input  logic            item_pop
);

  sdfe_pkg::item_t item_in;
  logic            q_empty;

  // A zero byte ends the text.
  always_comb begin
    item_in.is_term   = (text_byte == 8'd0);
    item_in.text_byte = text_byte;
  end

  sdfe_fifo #(
    .WIDTH($bits(sdfe_pkg::item_t)),
    .DEPTH(sdfe_pkg::IN_Q_DEPTH)
  ) u_in_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(item_in),
    .full   (full),
    .rd_en  (item_pop),
    .rd_data(item),
    .empty  (q_empty)
  );

  assign item_valid = !q_empty;

endmodule

>>> hdl/sdfe_engine.sv
// Back part: lookahead window, delimiter compare and frame tracking.
// One window position is examined per cycle while the result queue is not full; depends on sdfe_pkg.
module sdfe_engine #(
  parameter int SEP_MAX      = 8,
  parameter int SENT_MAX_LEN = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sdfe_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  sdfe_pkg::item_t   in_item,
  output logic              in_pop,
  input  logic              res_full,
  output logic              res_push,
  output sdfe_pkg::result_t res
);

  localparam int FILL_W = $clog2(SEP_MAX + 1);

  logic [7:0]        win_r   [SEP_MAX];
  logic [7:0]        win_v   [SEP_MAX];
  logic [7:0]        win_nxt [SEP_MAX];
  logic [FILL_W-1:0] fill_r, fill_v, fill_a, fill_nxt;
  logic              inside_r, inside_nxt;
  logic [4:0]        count_r, count_a, count_nxt;
  logic [7:0]        pos_r, pos1, pos_nxt;
  logic              ovf_r, ovf1, ovf_nxt;
  logic              busy_r, busy_nxt;
  logic              term_r, term_nxt;
  logic              h_valid_r, h_valid_nxt;
  logic              h_final_r, h_final_nxt;
  sdfe_pkg::result_t h_r, h_nxt;

  logic [3:0]         len_s, len_e, need;
  logic [4:0]         lim;
  logic [SEP_MAX-1:0] ok_s, ok_e;
  logic               run, take, cnt_ok, app, data_step, term_step, ex, fin;
  logic               start_hit, end_hit, ins1, emit;
  logic               cont, done, r_valid;
  sdfe_pkg::result_t  r;

  // Effective delimiter lengths, lookahead need and frame limit.
  always_comb begin
    len_s = (cfg.start_length == 4'd0) ? 4'd1 :
            (cfg.start_length > 4'(SEP_MAX)) ? 4'(SEP_MAX) : cfg.start_length;
    len_e = (cfg.end_length == 4'd0) ? 4'd1 :
            (cfg.end_length > 4'(SEP_MAX)) ? 4'(SEP_MAX) : cfg.end_length;
    need  = (len_e > len_s) ? len_e : len_s;
    lim   = (cfg.max_sentences == 5'd0 ||
             cfg.max_sentences > sdfe_pkg::FRAME_LIMIT_MAX) ?
            sdfe_pkg::FRAME_LIMIT_MAX : cfg.max_sentences;
  end

  // Window as seen this cycle, with the newly taken byte appended.
  always_comb begin
    run    = !res_full;
    take   = run && !busy_r && in_valid;
    cnt_ok = (count_r < lim);
    app    = take && !in_item.is_term && cnt_ok && (fill_r < FILL_W'(SEP_MAX));
    for (int k = 0; k < SEP_MAX; k++) begin
      win_v[k] = (app && fill_r == FILL_W'(k)) ? in_item.text_byte : win_r[k];
    end
    fill_v = app ? fill_r + 1'b1 : fill_r;
  end

  // Byte-wise delimiter compare at the head of the window.
  always_comb begin
    for (int k = 0; k < SEP_MAX; k++) begin
      ok_s[k] = (4'(k) >= len_s) ||
                ((FILL_W'(k) < fill_v) && (win_v[k] != 8'd0) &&
                 (win_v[k] == cfg.start_pattern[8*k +: 8]));
      ok_e[k] = (4'(k) >= len_e) ||
                ((FILL_W'(k) < fill_v) && (win_v[k] != 8'd0) &&
                 (win_v[k] == cfg.end_pattern[8*k +: 8]));
    end
  end

  always_comb begin
    in_pop    = take;
    data_step = busy_r ? (run && !term_r) : (take && !in_item.is_term && cnt_ok);
    term_step = busy_r ? (run && term_r) : (take && in_item.is_term);
    ex        = (data_step || term_step) && (fill_v != '0) && cnt_ok &&
                (!data_step || 4'(fill_v) >= need);
    fin       = term_step && !ex;

    start_hit = ex && !inside_r && (&ok_s);
    end_hit   = ex && inside_r && (&ok_e);
    ins1      = start_hit || (inside_r && !end_hit);
    pos1      = start_hit ? 8'd0 : pos_r;
    ovf1      = start_hit ? 1'b0 : ovf_r;
    emit      = ex && ins1 && (pos1 < 8'(SENT_MAX_LEN));
    count_a   = end_hit ? count_r + 1'b1 : count_r;
    fill_a    = ex ? fill_v - 1'b1 : fill_v;

    r = '0;
    r.kind = sdfe_pkg::KIND_BYTE;
    if (fin) begin
      r.kind     = sdfe_pkg::KIND_FIN;
      r.overflow = inside_r && ovf_r;
    end else if (end_hit) begin
      r.kind        = sdfe_pkg::KIND_CLOSE;
      r.frame_index = count_r[3:0];
      r.overflow    = ovf_r;
    end else if (emit) begin
      r.frame_byte    = win_v[0];
      r.frame_index   = count_r[3:0];
      r.byte_position = pos1[6:0];
    end
    r_valid = fin || end_hit || emit;

    cont = (data_step && ex && (fill_a != '0) && (4'(fill_a) >= need) &&
            (count_a < lim)) || (term_step && ex);
    done = !cont;

    for (int k = 0; k < SEP_MAX - 1; k++) begin
      win_nxt[k] = ex ? win_v[k+1] : win_v[k];
    end
    win_nxt[SEP_MAX-1] = ex ? 8'd0 : win_v[SEP_MAX-1];

    fill_nxt   = (fin || (data_step && !(count_a < lim))) ? '0 : fill_a;
    inside_nxt = fin ? 1'b0 : (ex ? ins1 : inside_r);
    count_nxt  = fin ? 5'd0 : count_a;
    pos_nxt    = fin ? 8'd0 : (ex ? (emit ? pos1 + 1'b1 : pos1) : pos_r);
    ovf_nxt    = fin ? 1'b0 : (ex ? ((ins1 && !emit) ? 1'b1 : ovf1) : ovf_r);
    busy_nxt   = cont;
    term_nxt   = term_step;

    // The held result goes out once it is known whether it ends its item.
    res_push = run && h_valid_r && (h_final_r || r_valid || done);
    res      = h_r;
    res.last = h_final_r || !r_valid;

    h_nxt       = h_r;
    h_valid_nxt = h_valid_r;
    h_final_nxt = h_final_r;
    if (r_valid) begin
      h_nxt       = r;
      h_valid_nxt = 1'b1;
      h_final_nxt = done;
    end else if (res_push) begin
      h_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      inside_r  <= 1'b0;
      count_r   <= 5'd0;
      pos_r     <= 8'd0;
      ovf_r     <= 1'b0;
      busy_r    <= 1'b0;
      term_r    <= 1'b0;
      h_valid_r <= 1'b0;
      h_final_r <= 1'b0;
    end else if (run) begin
      fill_r    <= fill_nxt;
      inside_r  <= inside_nxt;
      count_r   <= count_nxt;
      pos_r     <= pos_nxt;
      ovf_r     <= ovf_nxt;
      busy_r    <= busy_nxt;
      term_r    <= term_nxt;
      h_valid_r <= h_valid_nxt;
      h_final_r <= h_final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      win_r <= win_nxt;
      h_r   <= h_nxt;
    end
  end

endmodule

>>> hdl/start_end_delimited_frame_extractor.sv
// Delimited frame extractor: configuration registers, input queue, engine, result queue.
// Takes one byte per cycle while not full; the engine examines one window position
// per cycle while the result queue has room. A terminator drains the held bytes before
// its end result; shrinking a delimiter also makes the engine drain held bytes.
// Synchronous active-low reset empties both queues and the window and loads register defaults.
// Depends on sdfe_pkg, sdfe_front, sdfe_engine and sdfe_fifo.
module start_end_delimited_frame_extractor #(
  parameter int SEP_MAX      = 8,
  parameter int SENT_MAX_LEN = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_text_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_frame_byte,
  output logic [3:0]                      out_frame_index,
  output logic [6:0]                      out_byte_position,
  output logic                            out_overflow,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [sdfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdfe_pkg::CFG_DATA_W-1:0] cfg_data
);

  sdfe_pkg::cfg_t    cfg_r;
  sdfe_pkg::item_t   item;
  sdfe_pkg::result_t res, res_out;
  logic              item_valid, item_pop;
  logic              res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_pattern <= 64'd36;
      cfg_r.start_length  <= 4'd1;
      cfg_r.end_pattern   <= 64'd10;
      cfg_r.end_length    <= 4'd1;
      cfg_r.max_sentences <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        sdfe_pkg::CFG_START_PATTERN: cfg_r.start_pattern <= cfg_data;
        sdfe_pkg::CFG_START_LENGTH:  cfg_r.start_length  <= cfg_data[3:0];
        sdfe_pkg::CFG_END_PATTERN:   cfg_r.end_pattern   <= cfg_data;
        sdfe_pkg::CFG_END_LENGTH:    cfg_r.end_length    <= cfg_data[3:0];
        sdfe_pkg::CFG_MAX_SENTENCES: cfg_r.max_sentences <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  sdfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .text_byte (in_text_byte),
    .full      (full),
    .item_valid(item_valid),
    .item      (item),
    .item_pop  (item_pop)
  );

  sdfe_engine #(
    .SEP_MAX     (SEP_MAX),
    .SENT_MAX_LEN(SENT_MAX_LEN)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(item_valid),
    .in_item (item),
    .in_pop  (item_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res)
  );

  sdfe_fifo #(
    .WIDTH($bits(sdfe_pkg::result_t)),
    .DEPTH(sdfe_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_out),
    .empty  (empty)
  );

  assign out_kind          = res_out.kind;
  assign out_frame_byte    = res_out.frame_byte;
  assign out_frame_index   = res_out.frame_index;
  assign out_byte_position = res_out.byte_position;
  assign out_overflow      = res_out.overflow;
  assign out_last          = res_out.last;

endmodule

>>> test/frame_check_pkg.sv
// Checker class for the delimited frame extractor testbench: tracks the text state
// and register copies, predicts the results of each accepted byte and compares them.
// Depends on sdfe_pkg for the result type and the register and kind codes.
package frame_check_pkg;
  import sdfe_pkg::*;

  localparam int SEP_MAX      = 8;
  localparam int SENT_MAX_LEN = 128;
  localparam int MAX_REPORTS  = 10;

  class frame_checker;
    logic [63:0] start_pat;
    logic [3:0]  start_len;
    logic [63:0] end_pat;
    logic [3:0]  end_len;
    logic [4:0]  frame_limit_reg;

    logic [7:0]  window [SEP_MAX];
    int          fill;
    bit          in_frame;
    int          frames_done;
    int          pos;
    bit          dropped;

    result_t     awaited_results[$];
    int          errors;
    int          results_checked;
    int          closes_seen;
    int          overflows_seen;
    int          bytes_taken;

    function new();
      start_pat       = 64'd36;
      start_len       = 4'd1;
      end_pat         = 64'd10;
      end_len         = 4'd1;
      frame_limit_reg = FRAME_LIMIT_MAX;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = 8'd0;
      fill        = 0;
      in_frame    = 1'b0;
      frames_done = 0;
      pos         = 0;
      dropped     = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_START_PATTERN: start_pat = value;
        CFG_START_LENGTH: start_len = value[3:0];
        CFG_END_PATTERN: end_pat = value;
        CFG_END_LENGTH: end_len = value[3:0];
        CFG_MAX_SENTENCES: frame_limit_reg = value[4:0];
        default: ;
      endcase
    endfunction

    function int delim_len(logic [3:0] v);
      if (v == 4'd0) return 1;
      if (v > SEP_MAX) return SEP_MAX;
      return int'(v);
    endfunction

    function int frame_cap();
      if (frame_limit_reg == 5'd0 || frame_limit_reg > FRAME_LIMIT_MAX) begin
        return int'(FRAME_LIMIT_MAX);
      end
      return int'(frame_limit_reg);
    endfunction

    // A delimiter byte at or past the terminator, or not yet received, never matches.
    function bit head_matches(logic [63:0] pat, int len);
      for (int k = 0; k < len; k++) begin
        if (k >= fill || window[k] == 8'd0 || window[k] != pat[8*k +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void add_result(kind_t kind, logic [7:0] b, int idx, int p, bit ovf);
      result_t r;
      r.kind          = kind;
      r.frame_byte    = b;
      r.frame_index   = idx[3:0];
      r.byte_position = p[6:0];
      r.overflow      = ovf;
      r.last          = 1'b0;
      awaited_results.push_back(r);
    endfunction

    function void examine_head();
      logic [7:0] c;
      c = window[0];
      if (!in_frame && head_matches(start_pat, delim_len(start_len))) begin
        in_frame = 1'b1;
        pos      = 0;
        dropped  = 1'b0;
      end else if (in_frame && head_matches(end_pat, delim_len(end_len))) begin
        in_frame = 1'b0;
        add_result(KIND_CLOSE, 8'd0, frames_done, 0, dropped);
        frames_done++;
      end
      if (in_frame) begin
        if (pos < SENT_MAX_LEN) begin
          add_result(KIND_BYTE, c, frames_done, pos, 1'b0);
          pos++;
        end else begin
          dropped = 1'b1;
        end
      end
      if (fill > 0) begin
        for (int i = 0; i < SEP_MAX - 1; i++) window[i] = window[i+1];
        window[SEP_MAX-1] = 8'd0;
        fill--;
      end
    endfunction

    function void take_text_byte(logic [7:0] b);
      int cap;
      int need;
      int first;
      cap   = frame_cap();
      need  = delim_len(start_len);
      first = awaited_results.size();
      if (delim_len(end_len) > need) need = delim_len(end_len);
      bytes_taken++;
      if (b != 8'd0) begin
        if (frames_done >= cap) return;
        if (fill < SEP_MAX) begin
          window[fill] = b;
          fill++;
        end
        while (fill > 0 && fill >= need && frames_done < cap) examine_head();
        if (frames_done >= cap) begin
          foreach (window[i]) window[i] = 8'd0;
          fill = 0;
        end
      end else begin
        while (fill > 0 && frames_done < cap) examine_head();
        add_result(KIND_FIN, 8'd0, 0, 0, in_frame ? dropped : 1'b0);
        clear_text();
      end
      if (awaited_results.size() > first) begin
        awaited_results[awaited_results.size()-1].last = 1'b1;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_checked++;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Unexpected result: kind %0d byte %02h frame %0d pos %0d ovf %0b last %0b",
                   got.kind, got.frame_byte, got.frame_index, got.byte_position,
                   got.overflow, got.last);
        end
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind || got.frame_byte !== want.frame_byte ||
          got.frame_index !== want.frame_index ||
          got.byte_position !== want.byte_position ||
          got.overflow !== want.overflow || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Mismatch: expected kind %0d byte %02h frame %0d pos %0d ovf %0b last %0b",
                   want.kind, want.frame_byte, want.frame_index, want.byte_position,
                   want.overflow, want.last);
          $display("          actual   kind %0d byte %02h frame %0d pos %0d ovf %0b last %0b",
                   got.kind, got.frame_byte, got.frame_index, got.byte_position,
                   got.overflow, got.last);
        end
      end else begin
        if (got.kind == KIND_CLOSE) closes_seen++;
        if (got.overflow) overflows_seen++;
      end
    endfunction
  endclass

endpackage

>>> test/tb.sv
// Top-level testbench for start_end_delimited_frame_extractor: drives text bytes and
// register writes, pops results at random and checks each one against frame_checker.
// Depends on sdfe_pkg, frame_check_pkg and the block itself.
module tb;
  import sdfe_pkg::*;
  import frame_check_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEMS_PER_MODE = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            in_text_byte = 8'd0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [1:0]            out_kind;
  logic [7:0]            out_frame_byte;
  logic [3:0]            out_frame_index;
  logic [6:0]            out_byte_position;
  logic                  out_overflow;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_checker chk = new();
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           idle_cycles = 0;
  int           reg_writes = 0;
  int           texts_sent = 0;
  logic [7:0]   text_q[$];

  always #2 clk = ~clk;

  start_end_delimited_frame_extractor #(
    .SEP_MAX(SEP_MAX),
    .SENT_MAX_LEN(SENT_MAX_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_text_byte(in_text_byte),
    .empty(empty),
    .pop(pop),
    .out_kind(out_kind),
    .out_frame_byte(out_frame_byte),
    .out_frame_index(out_frame_index),
    .out_byte_position(out_byte_position),
    .out_overflow(out_overflow),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin : monitor
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_n && push && !full) begin
      chk.take_text_byte(in_text_byte);
      moved = 1'b1;
    end
    if (rst_n && pop && !empty) begin
      got.kind          = kind_t'(out_kind);
      got.frame_byte    = out_frame_byte;
      got.frame_index   = out_frame_index;
      got.byte_position = out_byte_position;
      got.overflow      = out_overflow;
      got.last          = out_last;
      chk.check_result(got);
      moved = 1'b1;
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer in %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_queued();
    foreach (text_q[i]) begin
      while ($urandom_range(99) < send_idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push         <= 1'b1;
      in_text_byte <= text_q[i];
      do @(posedge clk); while (full);
      if (text_q[i] == 8'd0) texts_sent++;
    end
    text_q.delete();
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    while (chk.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    chk.write_reg(idx, value);
    reg_writes++;
  endtask

  task automatic load_registers(logic [63:0] sp, logic [3:0] sl, logic [63:0] ep,
                                logic [3:0] el, logic [4:0] ms);
    write_reg(CFG_START_PATTERN, sp);
    write_reg(CFG_START_LENGTH, 64'(sl));
    write_reg(CFG_END_PATTERN, ep);
    write_reg(CFG_END_LENGTH, 64'(el));
    write_reg(CFG_MAX_SENTENCES, 64'(ms));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [3:0] pick_length();
    case ($urandom_range(9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic load_random_registers();
    logic [63:0] sp;
    logic [63:0] ep;
    logic [4:0]  ms;
    sp = {$urandom, $urandom};
    ep = {$urandom, $urandom};
    case ($urandom_range(19))
      0: sp = '1;
      1: sp = '0;
      2: ep = '1;
      3: ep = '0;
      default: ;
    endcase
    case ($urandom_range(9))
      0: ms = 5'd0;
      1: ms = 5'($urandom_range(17, 31));
      2: ms = 5'd1;
      3: ms = 5'd16;
      default: ms = 5'($urandom_range(1, 16));
    endcase
    load_registers(sp, pick_length(), ep, pick_length(), ms);
  endtask

  // Arbitrary bytes, with delimiter bytes mixed in half the time so partial matches occur.
  function automatic logic [7:0] text_filler();
    int k;
    case ($urandom_range(3))
      0: begin
        k = $urandom_range(chk.delim_len(chk.start_len) - 1);
        return chk.start_pat[8*k +: 8];
      end
      1: begin
        k = $urandom_range(chk.delim_len(chk.end_len) - 1);
        return chk.end_pat[8*k +: 8];
      end
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void push_delimiter(logic [63:0] pat, int len);
    for (int k = 0; k < len; k++) text_q.push_back(pat[8*k +: 8]);
  endfunction

  // Well-formed frames with random content, or at times only random bytes; some delimiters are cut short or left out,
  // and a terminator may land inside a frame.
  function automatic void build_text();
    int slen;
    int elen;
    int frames;
    int mishap;
    slen = chk.delim_len(chk.start_len);
    elen = chk.delim_len(chk.end_len);
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      frames = ($urandom_range(9) == 0) ? $urandom_range(12, 18) : $urandom_range(4);
      repeat (frames) begin
        repeat ($urandom_range(3)) text_q.push_back(text_filler());
        mishap = $urandom_range(9);
        push_delimiter(chk.start_pat, (mishap == 0) ? slen - 1 : slen);
        repeat ((frames > 8) ? $urandom_range(3) : $urandom_range(12)) begin
          text_q.push_back(text_filler());
        end
        if (mishap == 1) text_q.push_back(8'd0);
        if (mishap != 2) push_delimiter(chk.end_pat, elen);
      end
    end
    text_q.push_back(8'd0);
  endfunction

  // One frame longer than the frame byte limit, so its tail is dropped.
  function automatic void build_long_frame(bit close_it);
    logic [7:0] b;
    push_delimiter(chk.start_pat, chk.delim_len(chk.start_len));
    repeat ($urandom_range(129, 134)) begin
      do b = 8'($urandom_range(1, 255)); while (b == chk.end_pat[7:0]);
      text_q.push_back(b);
    end
    if (close_it) push_delimiter(chk.end_pat, chk.delim_len(chk.end_len));
    text_q.push_back(8'd0);
  endfunction

  initial begin : stimulus
    int mode_items;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: stray delimiters, byte extremes, open frame at the terminator.
    text_q = '{8'h0A, 8'h24, 8'hFF, 8'h01, 8'h80, 8'h24, 8'h0A, 8'h71, 8'h00};
    send_queued();
    text_q = '{8'h24, 8'h61, 8'h00};
    send_queued();
    text_q = '{8'h00};
    send_queued();

    // Zero start length, oversize end length and a frame limit of one.
    wait_for_results();
    load_registers(64'hA5A5_A5A5_A5A5_A553, 4'd0, 64'h4545_4545_4545_4545, 4'd9, 5'd1);
    text_q = '{8'h53, 8'h78, 8'h45, 8'h45, 8'h45, 8'h45, 8'h45, 8'h45, 8'h45, 8'h45,
               8'h53, 8'h79, 8'h00};
    send_queued();

    // Delimiters holding a zero byte never match; shrinking them mid-text
    // releases the held bytes at the next byte.
    wait_for_results();
    load_registers(64'h0000_0000_0000_005A, 4'd2, 64'h0000_0000_0000_003B, 4'd15, 5'd0);
    text_q = '{8'h5A, 8'h5A, 8'h5A};
    send_queued();
    wait_for_results();
    load_registers(64'h0000_0000_0000_005A, 4'd1, 64'h0000_0000_0000_003B, 4'd1, 5'd31);
    text_q = '{8'h6B, 8'h00};
    send_queued();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 74 : 0;
      recv_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 37 : 0;
      mode_items = 0;
      while (mode_items < ITEMS_PER_MODE) begin
        if (mode_items == 0 && mode != 1) begin
          wait_for_results();
          load_registers(64'h24, 4'd1, 64'h0A0D, 4'd2, 5'd16);
          build_long_frame(mode == 0);
        end else begin
          if ($urandom_range(2) == 0) begin
            wait_for_results();
            load_random_registers();
          end
          build_text();
        end
        mode_items += text_q.size();
        send_queued();
      end
    end

    wait_for_results();
    $display("Sent %0d text bytes in %0d texts with %0d register writes.",
             chk.bytes_taken, texts_sent, reg_writes);
    $display("Checked %0d results: %0d frames closed, %0d with dropped bytes.",
             chk.results_checked, chk.closes_seen, chk.overflows_seen);
    if (chk.awaited_results.size() != 0) begin
      $display("%0d expected results never arrived", chk.awaited_results.size());
    end
    if (chk.errors == 0 && chk.awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> start_end_delimited_frame_extractor.f
hdl/sdfe_pkg.sv
hdl/sdfe_fifo.sv
hdl/sdfe_front.sv
hdl/sdfe_engine.sv
hdl/start_end_delimited_frame_extractor.sv
test/frame_check_pkg.sv
test/tb.sv
